// ===== rtl/core/crc16_stream_checksum_defines.svh =====
`ifndef CRC16_STREAM_CHECKSUM_DEFINES_SVH
`define CRC16_STREAM_CHECKSUM_DEFINES_SVH

// Same-cycle implication, sampled on aclk and masked while aresetn is low.
`define CRC16S_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk and masked while aresetn is low.
`define CRC16S_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/crc16s_pkg.sv =====
`timescale 1ns / 1ps

package crc16s_pkg;

    localparam logic [15:0] CRC_SEED   = 16'hFFFF;
    localparam logic [15:0] CRC_XOROUT = 16'hFFFF;
    localparam logic [15:0] POLY_RESET = 16'h1021;

    typedef struct packed {
        logic       last;
        logic [7:0] data;
    } item_t;

    // Folds one byte into the register, MSB first, eight shift steps.
    function automatic logic [15:0] crc16s_absorb(input logic [15:0] crc_in,
                                                  input logic [7:0]  data,
                                                  input logic [15:0] poly);
        logic [15:0] crc;
        crc = crc_in ^ {data, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (crc[15]) begin
                crc = {crc[14:0], 1'b0} ^ poly;
            end else begin
                crc = {crc[14:0], 1'b0};
            end
        end
        return crc;
    endfunction

endpackage

// ===== rtl/core/crc16_stream_checksum.sv =====
// A byte transfer is registered at the input and folded into the CRC as it leaves; a last
// byte loads the checksum into the output register that drives m_tdata.
// Throughput: one byte per cycle; the eight-step byte update sits between two registers.
// A stalled result only holds back the next last byte, not the bytes before it.
// Reset (aresetn low, synchronous): CRC reloads 0xFFFF, polynomial 0x1021, both stages empty.
`timescale 1ns / 1ps
`include "crc16_stream_checksum_defines.svh"

module crc16_stream_checksum
    import crc16s_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data,   // polynomial[15:0]
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // data_byte[7:0]
    input  logic        s_tlast,    // last_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata     // crc_high[7:0], crc_low[15:8]
);

    logic        item_valid;
    item_t       item;
    logic        consume;
    logic        out_free;
    logic        out_load;
    logic [15:0] crc_result;
    logic [15:0] crc_state;

    // A byte leaves the input register unless it is a last byte facing a full output.
    assign consume  = item_valid && (!item.last || out_free);
    assign out_load = consume && item.last;

    crc16s_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .consume    (consume),
        .item_valid (item_valid),
        .item       (item)
    );

    crc16s_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .consume    (consume),
        .item       (item),
        .crc_result (crc_result),
        .crc_state  (crc_state)
    );

    crc16s_out_reg u_out_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (out_load),
        .crc_result (crc_result),
        .free       (out_free),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

    `CRC16S_ASSERT_NEXT(a_seed_after_last, out_load, crc_state == CRC_SEED,
        "CRC not reseeded after last byte")
    `CRC16S_ASSERT_NOW(a_result_needs_last, $rose(m_tvalid), $past(out_load),
        "Result without a last byte")
    `CRC16S_ASSERT_NEXT(a_result_value, out_load,
        m_tvalid && m_tdata == {$past(crc_result[7:0]), $past(crc_result[15:8])},
        "Result does not match folded CRC")

endmodule

// ===== rtl/core/crc16s_in_reg.sv =====
`timescale 1ns / 1ps

module crc16s_in_reg
    import crc16s_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // data_byte[7:0]
    input  logic        s_tlast,   // last_byte
    input  logic        consume,
    output logic        item_valid,
    output item_t       item
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    assign s_tready   = !valid_reg || consume;
    assign valid_next = s_tready ? s_tvalid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg <= '{last: s_tlast, data: s_tdata};
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// ===== rtl/core/crc16s_core.sv =====
`timescale 1ns / 1ps

module crc16s_core
    import crc16s_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data,
    input  logic        consume,
    input  item_t       item,
    output logic [15:0] crc_result,
    output logic [15:0] crc_state
);

    logic [15:0] poly_reg;
    logic [15:0] crc_reg;
    logic [15:0] crc_next;
    logic [15:0] crc_upd;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            poly_reg <= POLY_RESET;
        end else if (cfg_valid) begin
            poly_reg <= cfg_data;
        end
    end

    assign crc_upd = crc16s_absorb(crc_reg, item.data, poly_reg);

    // The last byte of a message reloads the seed for the next message.
    always_comb begin
        crc_next = crc_reg;
        if (consume) begin
            crc_next = item.last ? CRC_SEED : crc_upd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_reg <= CRC_SEED;
        end else begin
            crc_reg <= crc_next;
        end
    end

    assign crc_result = crc_upd ^ CRC_XOROUT;
    assign crc_state  = crc_reg;

endmodule

// ===== rtl/core/crc16s_out_reg.sv =====
`timescale 1ns / 1ps

module crc16s_out_reg
    import crc16s_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        load,
    input  logic [15:0] crc_result,
    output logic        free,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // crc_high[7:0], crc_low[15:8]
);

    logic        valid_reg;
    logic        valid_next;
    logic [15:0] data_reg;

    assign free = !valid_reg || m_tready;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= {crc_result[7:0], crc_result[15:8]};
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;

endmodule
